// ===== rtl/core/sacl_pkg.sv =====
`default_nettype none

package sacl_pkg;

   // fixed field widths of the access and result items
   localparam int ADDR_W      = 32;
   localparam int BYTES_W     = 7;
   localparam int WAY_OUT_W   = 3;
   localparam int STAMP_W     = 32;

   // geometry defaults
   localparam int SETS_DEF        = 64;
   localparam int WAYS_DEF        = 8;
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int ADDR_BITS_DEF   = 32;

   // access kinds
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // control register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRU_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_MODE = 1'd1;

endpackage

`default_nettype wire

// ===== rtl/core/sacl_req_if.sv =====
`default_nettype none

interface sacl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [sacl_pkg::ADDR_W-1:0]  address;
   logic [sacl_pkg::BYTES_W-1:0] byte_count;

   modport source (output valid, output action, output address, output byte_count,
                   input ready);
   modport sink   (input valid, input action, input address, input byte_count,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sacl_rsp_if.sv =====
`default_nettype none

interface sacl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [sacl_pkg::WAY_OUT_W-1:0] way;
   logic                           writeback_valid;
   logic [sacl_pkg::ADDR_W-1:0]    writeback_address;
   logic                           fill_valid;
   logic [sacl_pkg::ADDR_W-1:0]    fill_address;
   logic                           forward_valid;
   logic [sacl_pkg::BYTES_W-1:0]   forward_byte_count;

   modport source (output valid, output hit, output way, output writeback_valid,
                   output writeback_address, output fill_valid, output fill_address,
                   output forward_valid, output forward_byte_count, input ready);
   modport sink   (input valid, input hit, input way, input writeback_valid,
                   input writeback_address, input fill_valid, input fill_address,
                   input forward_valid, input forward_byte_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/set_assoc_cache_lru_controller.sv =====
`default_nettype none

// One access at a time: a new access is accepted only in ST_IDLE, after the previous
// result has been loaded; one tag/stamp comparator walks the ways of the set one per
// cycle after a registered set read.
// Reset: synchronous; afterwards a clearing pass writes every one of the SETS sets
// (64 by default) once before the first access is taken.
module set_assoc_cache_lru_controller #(
   parameter int SETS        = sacl_pkg::SETS_DEF,
   parameter int WAYS        = sacl_pkg::WAYS_DEF,
   parameter int BLOCK_BYTES = sacl_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = sacl_pkg::ADDR_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sacl_req_if.sink                             req_bus,
   sacl_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_wr_en,
   input  wire logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   // address geometry
   localparam int S_BITS    = (SETS > 1) ? $clog2(SETS) : 0;
   localparam int B_BITS    = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
   localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int EFF_ADDR  = (ADDR_BITS < sacl_pkg::ADDR_W) ? ADDR_BITS : sacl_pkg::ADDR_W;
   localparam int TAG_SHIFT = S_BITS + B_BITS;
   localparam int TAG_RAW   = EFF_ADDR - TAG_SHIFT;
   localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam logic [sacl_pkg::ADDR_W-1:0] AMASK =
      (ADDR_BITS >= sacl_pkg::ADDR_W) ? '1 :
      sacl_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [sacl_pkg::ADDR_W-1:0] BLOCK_MASK = sacl_pkg::ADDR_W'(BLOCK_BYTES - 1);
   localparam logic [sacl_pkg::ADDR_W-1:0] SET_MASK   = sacl_pkg::ADDR_W'(SETS - 1);
   localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(SETS - 1);
   localparam logic [WAY_IW-1:0] LAST_WAY  = WAY_IW'(WAYS - 1);
   localparam logic [sacl_pkg::STAMP_W-1:0] STAMP_MAX = '1;

   typedef struct packed {
      logic                          valid;
      logic                          dirty;
      logic [TAG_W-1:0]              tag;
      logic [sacl_pkg::STAMP_W-1:0]  stamp;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam int ROW_W = $bits(row_type);

   // control state
   state_type                     state_ff, state_in;
   logic                          clear_busy_ff, clear_busy_in;
   logic [SET_W-1:0]              clear_idx_ff, clear_idx_in;
   logic [WAY_IW-1:0]             way_cnt_ff, way_cnt_in;
   logic [sacl_pkg::STAMP_W-1:0]  counter_ff, counter_in;
   logic                          thru_mode_ff, thru_mode_in;
   logic                          alloc_mode_ff, alloc_mode_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // access captured at accept
   logic                          action_ff, action_in;
   logic [sacl_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [sacl_pkg::BYTES_W-1:0]  bytes_ff, bytes_in;

   // scan results
   logic                          hit_found_ff, hit_found_in;
   logic [WAY_IW-1:0]             hit_way_ff, hit_way_in;
   logic                          inv_found_ff, inv_found_in;
   logic [WAY_IW-1:0]             inv_way_ff, inv_way_in;
   logic [sacl_pkg::STAMP_W-1:0]  least_ff, least_in;
   logic [WAY_IW-1:0]             least_way_ff, least_way_in;

   // result register
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [sacl_pkg::WAY_OUT_W-1:0] rsp_way_ff, rsp_way_in;
   logic                          rsp_wb_v_ff, rsp_wb_v_in;
   logic [sacl_pkg::ADDR_W-1:0]   rsp_wb_a_ff, rsp_wb_a_in;
   logic                          rsp_fill_v_ff, rsp_fill_v_in;
   logic [sacl_pkg::ADDR_W-1:0]   rsp_fill_a_ff, rsp_fill_a_in;
   logic                          rsp_fw_v_ff, rsp_fw_v_in;
   logic [sacl_pkg::BYTES_W-1:0]  rsp_fw_n_ff, rsp_fw_n_in;

   // set memory port signals
   logic                          req_accept;
   logic [sacl_pkg::ADDR_W-1:0]   req_addr_m;
   logic [SET_W-1:0]              req_set;
   logic [SET_W-1:0]              cur_set;
   logic [TAG_W-1:0]              cur_tag;
   logic [ROW_W-1:0]              ram_rd_data;
   logic                          ram_wr_en;
   logic [SET_W-1:0]              ram_wr_addr;
   row_type                       row_rd;
   row_type                       row_wr;
   line_type                      scan_line;
   line_type                      new_line;
   logic                          finish_go;
   logic [WAY_IW-1:0]             victim;

   assign req_bus.ready = (state_ff == ST_IDLE) && !clear_busy_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_addr_m    = req_bus.address & AMASK;
   assign req_set       = SET_W'((req_addr_m >> B_BITS) & SET_MASK);
   assign cur_set       = SET_W'((addr_ff >> B_BITS) & SET_MASK);
   assign cur_tag       = TAG_W'(addr_ff >> TAG_SHIFT);
   assign row_rd        = row_type'(ram_rd_data);
   assign scan_line     = row_rd[way_cnt_ff];
   assign finish_go     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);
   assign victim        = inv_found_ff ? inv_way_ff : least_way_ff;

   // one row per set holds every way's valid, dirty, tag and stamp
   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (clear_busy_ff ? ROW_W'(0) : ROW_W'(row_wr)),
      .rd_en   (req_accept),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en   = clear_busy_ff || finish_go;
   assign ram_wr_addr = clear_busy_ff ? clear_idx_ff : cur_set;

   // next-state logic
   always_comb begin
      state_in          = state_ff;
      clear_busy_in     = clear_busy_ff;
      clear_idx_in      = clear_idx_ff;
      way_cnt_in        = way_cnt_ff;
      counter_in        = counter_ff;
      thru_mode_in      = thru_mode_ff;
      alloc_mode_in     = alloc_mode_ff;
      rsp_valid_in      = rsp_valid_ff;
      action_in         = action_ff;
      addr_in           = addr_ff;
      bytes_in          = bytes_ff;
      hit_found_in      = hit_found_ff;
      hit_way_in        = hit_way_ff;
      inv_found_in      = inv_found_ff;
      inv_way_in        = inv_way_ff;
      least_in          = least_ff;
      least_way_in      = least_way_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_way_in        = rsp_way_ff;
      rsp_wb_v_in       = rsp_wb_v_ff;
      rsp_wb_a_in       = rsp_wb_a_ff;
      rsp_fill_v_in     = rsp_fill_v_ff;
      rsp_fill_a_in     = rsp_fill_a_ff;
      rsp_fw_v_in       = rsp_fw_v_ff;
      rsp_fw_n_in       = rsp_fw_n_ff;
      row_wr            = row_rd;
      new_line          = row_rd[victim];

      // control registers
      if (csr_wr_en) begin
         case (csr_index)
            sacl_pkg::CSR_THRU_MODE:  thru_mode_in  = csr_wr_data[0];
            sacl_pkg::CSR_ALLOC_MODE: alloc_mode_in = csr_wr_data[0];
            default: ;
         endcase
      end

      // clearing pass after reset
      if (clear_busy_ff) begin
         clear_idx_in = clear_idx_ff + 1'b1;
         if (clear_idx_ff == LAST_SET) begin
            clear_busy_in = 1'b0;
         end
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in    = req_bus.action;
               addr_in      = req_addr_m;
               bytes_in     = req_bus.byte_count;
               counter_in   = (counter_ff == STAMP_MAX) ? counter_ff : counter_ff + 1'b1;
               hit_found_in = 1'b0;
               inv_found_in = 1'b0;
               way_cnt_in   = '0;
               state_in     = ST_SCAN;
            end
         end

         // one way per cycle through the shared tag and stamp comparator
         ST_SCAN: begin
            if (!hit_found_ff && scan_line.valid && (scan_line.tag == cur_tag)) begin
               hit_found_in = 1'b1;
               hit_way_in   = way_cnt_ff;
            end
            if (!inv_found_ff && !scan_line.valid) begin
               inv_found_in = 1'b1;
               inv_way_in   = way_cnt_ff;
            end
            if ((way_cnt_ff == '0) || (scan_line.stamp < least_ff)) begin
               least_in     = scan_line.stamp;
               least_way_in = way_cnt_ff;
            end
            way_cnt_in = way_cnt_ff + 1'b1;
            if (way_cnt_ff == LAST_WAY) begin
               state_in = ST_FINISH;
            end
         end

         // decide, update the set row and load the result
         ST_FINISH: begin
            rsp_hit_in    = hit_found_ff;
            rsp_way_in    = '0;
            rsp_wb_v_in   = 1'b0;
            rsp_wb_a_in   = '0;
            rsp_fill_v_in = 1'b0;
            rsp_fill_a_in = '0;
            rsp_fw_v_in   = 1'b0;
            if (hit_found_ff) begin
               rsp_way_in = sacl_pkg::WAY_OUT_W'(hit_way_ff);
               row_wr[hit_way_ff].stamp = counter_ff;
               if (action_ff == sacl_pkg::ACTION_WRITE) begin
                  if (thru_mode_ff) begin
                     rsp_fw_v_in = 1'b1;
                  end else begin
                     row_wr[hit_way_ff].dirty = 1'b1;
                  end
               end
            end else if ((action_ff == sacl_pkg::ACTION_WRITE) && !alloc_mode_ff) begin
               rsp_fw_v_in = 1'b1;
            end else begin
               rsp_way_in = sacl_pkg::WAY_OUT_W'(victim);
               if (!inv_found_ff && row_rd[victim].dirty) begin
                  rsp_wb_v_in = 1'b1;
                  rsp_wb_a_in = ((sacl_pkg::ADDR_W'(row_rd[victim].tag) << TAG_SHIFT) |
                                 (sacl_pkg::ADDR_W'(cur_set) << B_BITS)) & AMASK;
               end
               rsp_fill_v_in  = 1'b1;
               rsp_fill_a_in  = addr_ff & ~BLOCK_MASK;
               new_line.valid = 1'b1;
               new_line.tag   = cur_tag;
               new_line.stamp = counter_ff;
               new_line.dirty = 1'b0;
               if (action_ff == sacl_pkg::ACTION_WRITE) begin
                  if (thru_mode_ff) begin
                     rsp_fw_v_in = 1'b1;
                  end else begin
                     new_line.dirty = 1'b1;
                  end
               end
               row_wr[victim] = new_line;
            end
            rsp_fw_n_in = rsp_fw_v_in ? bytes_ff : '0;

            if (!finish_go) begin
               rsp_hit_in    = rsp_hit_ff;
               rsp_way_in    = rsp_way_ff;
               rsp_wb_v_in   = rsp_wb_v_ff;
               rsp_wb_a_in   = rsp_wb_a_ff;
               rsp_fill_v_in = rsp_fill_v_ff;
               rsp_fill_a_in = rsp_fill_a_ff;
               rsp_fw_v_in   = rsp_fw_v_ff;
               rsp_fw_n_in   = rsp_fw_n_ff;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         clear_busy_ff     <= 1'b1;
         clear_idx_ff      <= '0;
         way_cnt_ff        <= '0;
         counter_ff        <= '0;
         thru_mode_ff      <= 1'b0;
         alloc_mode_ff     <= 1'b1;
         rsp_valid_ff      <= 1'b0;
         hit_found_ff      <= 1'b0;
         inv_found_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clear_busy_ff     <= clear_busy_in;
         clear_idx_ff      <= clear_idx_in;
         way_cnt_ff        <= way_cnt_in;
         counter_ff        <= counter_in;
         thru_mode_ff      <= thru_mode_in;
         alloc_mode_ff     <= alloc_mode_in;
         rsp_valid_ff      <= rsp_valid_in;
         hit_found_ff      <= hit_found_in;
         inv_found_ff      <= inv_found_in;
      end
      action_ff     <= action_in;
      addr_ff       <= addr_in;
      bytes_ff      <= bytes_in;
      hit_way_ff    <= hit_way_in;
      inv_way_ff    <= inv_way_in;
      least_ff      <= least_in;
      least_way_ff  <= least_way_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_wb_v_ff   <= rsp_wb_v_in;
      rsp_wb_a_ff   <= rsp_wb_a_in;
      rsp_fill_v_ff <= rsp_fill_v_in;
      rsp_fill_a_ff <= rsp_fill_a_in;
      rsp_fw_v_ff   <= rsp_fw_v_in;
      rsp_fw_n_ff   <= rsp_fw_n_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.hit                = rsp_hit_ff;
   assign rsp_bus.way                = rsp_way_ff;
   assign rsp_bus.writeback_valid    = rsp_wb_v_ff;
   assign rsp_bus.writeback_address  = rsp_wb_a_ff;
   assign rsp_bus.fill_valid         = rsp_fill_v_ff;
   assign rsp_bus.fill_address       = rsp_fill_a_ff;
   assign rsp_bus.forward_valid      = rsp_fw_v_ff;
   assign rsp_bus.forward_byte_count = rsp_fw_n_ff;
endmodule

`default_nettype wire

// ===== rtl/core/sacl_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== tb/tb_set_assoc_cache_lru_controller.sv =====
`default_nettype none

module tb_set_assoc_cache_lru_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 20;
   localparam int ADDR_W       = sacl_pkg::ADDR_W;
   localparam int BYTES_W      = sacl_pkg::BYTES_W;
   localparam int WAY_OUT_W    = sacl_pkg::WAY_OUT_W;
   localparam int STAMP_W      = sacl_pkg::STAMP_W;
   localparam int NUM_SETS     = sacl_pkg::SETS_DEF;
   localparam int NUM_WAYS     = sacl_pkg::WAYS_DEF;
   localparam int OFFSET_W     = $clog2(sacl_pkg::BLOCK_BYTES_DEF);
   localparam int SET_W        = $clog2(sacl_pkg::SETS_DEF);
   localparam int TAG_W        = ADDR_W - SET_W - OFFSET_W;
   localparam int LATENCY      = sacl_pkg::WAYS_DEF + 2;
   localparam int MAX_GAP      = 14;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 245;
   localparam int HOT_SETS     = 4;
   localparam int TAG_POOL     = 12;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 writeback_valid;
      logic [ADDR_W-1:0]    writeback_address;
      logic                 fill_valid;
      logic [ADDR_W-1:0]    fill_address;
      logic                 forward_valid;
      logic [BYTES_W-1:0]   forward_byte_count;
   } cache_result_type;

   // tag/metadata mirror of the cache plus the queue of outcomes still due
   class cache_scoreboard;
      bit                 thru_mode;
      bit                 alloc_mode;
      bit                 line_ok    [NUM_SETS][NUM_WAYS];
      bit                 line_dirty [NUM_SETS][NUM_WAYS];
      logic [TAG_W-1:0]   line_tag   [NUM_SETS][NUM_WAYS];
      logic [STAMP_W-1:0] line_stamp [NUM_SETS][NUM_WAYS];
      logic [STAMP_W-1:0] stamp_counter;
      cache_result_type   due_outcomes[$];
      int                 errors;

      function new();
         thru_mode     = 1'b0;
         alloc_mode    = 1'b1;
         stamp_counter = '0;
         errors        = 0;
         foreach (line_ok[s, w]) begin
            line_ok[s][w]    = 1'b0;
            line_dirty[s][w] = 1'b0;
            line_tag[s][w]   = '0;
            line_stamp[s][w] = '0;
         end
      endfunction

      function void write_reg(logic [sacl_pkg::CSR_IDX_W-1:0] idx,
                              logic [sacl_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            sacl_pkg::CSR_THRU_MODE:  thru_mode  = data[0];
            sacl_pkg::CSR_ALLOC_MODE: alloc_mode = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_outcomes.size();
      endfunction

      // works out the lookup outcome of one accepted access and updates the set
      function void note_access(logic action, logic [ADDR_W-1:0] addr,
                                logic [BYTES_W-1:0] count);
         logic [SET_W-1:0]   set_idx;
         logic [TAG_W-1:0]   tag;
         logic [STAMP_W-1:0] least;
         cache_result_type   r;
         bit                 is_read;
         bit                 found;
         int                 victim;
         set_idx = addr[OFFSET_W +: SET_W];
         tag     = addr[ADDR_W-1 -: TAG_W];
         is_read = (action == sacl_pkg::ACTION_READ);
         r       = '0;
         found   = 1'b0;
         if (stamp_counter != '1)
            stamp_counter++;

         for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && line_ok[set_idx][w] && line_tag[set_idx][w] == tag) begin
               found = 1'b1;
               r.way = WAY_OUT_W'(w);
            end
         end

         if (found) begin
            r.hit = 1'b1;
            line_stamp[set_idx][r.way] = stamp_counter;
            if (!is_read) begin
               if (thru_mode)
                  r.forward_valid = 1'b1;
               else
                  line_dirty[set_idx][r.way] = 1'b1;
            end
         end else if (!is_read && !alloc_mode) begin
            r.forward_valid = 1'b1;
         end else begin
            // first invalid way, else least stamp with lowest way on ties
            victim = -1;
            for (int w = 0; w < NUM_WAYS; w++)
               if (victim < 0 && !line_ok[set_idx][w])
                  victim = w;
            if (victim < 0) begin
               victim = 0;
               least  = line_stamp[set_idx][0];
               for (int w = 1; w < NUM_WAYS; w++) begin
                  if (line_stamp[set_idx][w] < least) begin
                     least  = line_stamp[set_idx][w];
                     victim = w;
                  end
               end
            end
            if (line_ok[set_idx][victim] && line_dirty[set_idx][victim]) begin
               r.writeback_valid   = 1'b1;
               r.writeback_address = {line_tag[set_idx][victim], set_idx, {OFFSET_W{1'b0}}};
            end
            r.fill_valid   = 1'b1;
            r.fill_address = {addr[ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};
            line_ok[set_idx][victim]    = 1'b1;
            line_tag[set_idx][victim]   = tag;
            line_stamp[set_idx][victim] = stamp_counter;
            line_dirty[set_idx][victim] = !is_read && !thru_mode;
            if (!is_read && thru_mode)
               r.forward_valid = 1'b1;
            r.way = WAY_OUT_W'(victim);
         end

         if (r.forward_valid)
            r.forward_byte_count = count;
         due_outcomes.push_back(r);
      endfunction

      function int field_differs(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      function void check_result(cache_result_type got);
         cache_result_type want;
         if (due_outcomes.size() == 0) begin
            $display("%0t: unexpected result item: expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = due_outcomes.pop_front();
         errors += field_differs("hit", want.hit, got.hit);
         errors += field_differs("way", want.way, got.way);
         errors += field_differs("writeback_valid", want.writeback_valid, got.writeback_valid);
         errors += field_differs("writeback_address", want.writeback_address,
                                 got.writeback_address);
         errors += field_differs("fill_valid", want.fill_valid, got.fill_valid);
         errors += field_differs("fill_address", want.fill_address, got.fill_address);
         errors += field_differs("forward_valid", want.forward_valid, got.forward_valid);
         errors += field_differs("forward_byte_count", want.forward_byte_count,
                                 got.forward_byte_count);
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sacl_pkg::CSR_DATA_W-1:0] csr_wr_data;

   sacl_req_if req_bus();
   sacl_rsp_if rsp_bus();

   cache_scoreboard sb = new();

   bit               no_idle = 1'b0;
   int               quiet_cycles = 0;
   logic [SET_W-1:0] hot_set  [HOT_SETS];
   logic [TAG_W-1:0] tag_pool [TAG_POOL];

   set_assoc_cache_lru_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag,
                                                   logic [SET_W-1:0] set_idx,
                                                   logic [OFFSET_W-1:0] offset);
      return {tag, set_idx, offset};
   endfunction

   // one access item; valid stays high into the next item when no gap is drawn
   task automatic send_access(logic action, logic [ADDR_W-1:0] addr,
                              logic [BYTES_W-1:0] count);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= action;
      req_bus.address    <= addr;
      req_bus.byte_count <= count;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold off until every outcome has come back, then let the pipeline settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_config(logic thru, logic alloc);
      csr_wr_en   <= 1'b1;
      csr_index   <= sacl_pkg::CSR_THRU_MODE;
      csr_wr_data <= thru;
      @(posedge clock);
      csr_index   <= sacl_pkg::CSR_ALLOC_MODE;
      csr_wr_data <= alloc;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_directed();
      write_config(1'b0, 1'b1);
      // write-back, allocate: fill, hit, dirty, address extremes
      send_access(sacl_pkg::ACTION_READ,  32'h0000_0000, 7'd1);
      send_access(sacl_pkg::ACTION_READ,  32'h0000_003F, 7'd64);
      send_access(sacl_pkg::ACTION_WRITE, 32'h0000_0020, 7'd127);
      send_access(sacl_pkg::ACTION_READ,  32'hFFFF_FFFF, 7'd0);
      send_access(sacl_pkg::ACTION_WRITE, 32'hFFFF_FFC0, 7'd64);
      // fill the rest of set 0 with dirty lines, then evict by LRU
      for (int t = 1; t < NUM_WAYS; t++)
         send_access(sacl_pkg::ACTION_WRITE, make_addr(TAG_W'(t), '0, '0), 7'd8);
      send_access(sacl_pkg::ACTION_READ, make_addr(TAG_W'(1), '0, '0), 7'd4);
      send_access(sacl_pkg::ACTION_READ, make_addr(TAG_W'(8), '0, '0), 7'd4);
      send_access(sacl_pkg::ACTION_READ, make_addr(TAG_W'(9), '0, 6'h3F), 7'd4);
      drain();

      // write-through with allocate: hit forwards, miss fills clean and forwards
      write_config(1'b1, 1'b1);
      send_access(sacl_pkg::ACTION_WRITE, make_addr(TAG_W'(1), '0, 6'h11), 7'd33);
      send_access(sacl_pkg::ACTION_WRITE, make_addr(TAG_W'(10), '0, '0), 7'd2);
      drain();

      // write-through, no allocate: write miss only forwards
      write_config(1'b1, 1'b0);
      send_access(sacl_pkg::ACTION_WRITE, make_addr(TAG_W'(11), 6'd1, '0), 7'd5);
      send_access(sacl_pkg::ACTION_WRITE, 32'hFFFF_FFC0, 7'd16);
      send_access(sacl_pkg::ACTION_READ,  make_addr(TAG_W'(11), 6'd1, '0), 7'd5);
      drain();

      // write-back, no allocate
      write_config(1'b0, 1'b0);
      send_access(sacl_pkg::ACTION_WRITE, make_addr(TAG_W'(12), 6'd1, '0), 7'd9);
      send_access(sacl_pkg::ACTION_WRITE, make_addr(TAG_W'(11), 6'd1, '0), 7'd9);
      send_access(sacl_pkg::ACTION_READ,  make_addr(20'h55555, 6'h2A, 6'h2A), 7'd85);
      send_access(sacl_pkg::ACTION_READ,  make_addr(20'hAAAAA, 6'h15, 6'h15), 7'd42);
      drain();
   endtask

   // few hot sets and a tag pool larger than the ways, so hits and evictions mix
   task automatic run_random_phase(logic thru, logic alloc);
      logic [ADDR_W-1:0]  addr;
      logic [BYTES_W-1:0] count;
      logic               action;
      foreach (hot_set[i])
         hot_set[i] = SET_W'($urandom);
      foreach (tag_pool[i])
         tag_pool[i] = TAG_W'($urandom);
      write_config(thru, alloc);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 40 == 0)
            no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) == 0)
            drain();
         if ($urandom_range(0, 9) < 2)
            addr = $urandom;
         else
            addr = make_addr(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                             hot_set[$urandom_range(0, HOT_SETS - 1)],
                             OFFSET_W'($urandom));
         if ($urandom_range(0, 7) == 0)
            count = BYTES_W'($urandom_range(0, 127));
         else
            count = BYTES_W'($urandom_range(1, 64));
         action = ($urandom_range(0, 1) == 1) ? sacl_pkg::ACTION_READ
                                              : sacl_pkg::ACTION_WRITE;
         send_access(action, addr, count);
      end
      drain();
   endtask

   // stimulus
   initial begin : stimulus
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= sacl_pkg::CSR_THRU_MODE;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= sacl_pkg::ACTION_READ;
      req_bus.address    <= '0;
      req_bus.byte_count <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random_phase(1'b1, 1'b1);
      run_random_phase(1'b0, 1'b0);
      run_random_phase(1'b1, 1'b0);
      run_random_phase(1'b0, 1'b1);
      run_random_phase(1'($urandom), 1'($urandom));
      repeat (2 * LATENCY) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // result side: random back-pressure
   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin : monitor
      cache_result_type seen;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_wr_en)
            sb.write_reg(csr_index, csr_wr_data);
         if (req_bus.valid && req_bus.ready) begin
            sb.note_access(req_bus.action, req_bus.address, req_bus.byte_count);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.hit                = rsp_bus.hit;
            seen.way                = rsp_bus.way;
            seen.writeback_valid    = rsp_bus.writeback_valid;
            seen.writeback_address  = rsp_bus.writeback_address;
            seen.fill_valid         = rsp_bus.fill_valid;
            seen.fill_address       = rsp_bus.fill_address;
            seen.forward_valid      = rsp_bus.forward_valid;
            seen.forward_byte_count = rsp_bus.forward_byte_count;
            sb.check_result(seen);
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

`default_nettype wire
